@@ rtl/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] CAPACITY_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
  } rsp_word_t;

endpackage

@@ rtl/lkvc_ram.sv @@
module lkvc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Channel    Signals                        Handshake
// request    start, busy, request           taken when start is high and busy is low
// response   response_valid, response       one-cycle strobe, no back pressure
// config     cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready
//
// Each word runs a search sweep over the key/value and rank memories (one read a
// cycle), a decision state, and for a hit or a put a rank update sweep. The
// response strobe comes at the end of the update sweep, or from the decision state
// for a get that misses. Busy drops in the strobe cycle. Reset empties the store at
// once (valid bits in flops) and sets capacity to 16.
module lru_key_value_cache #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lkvc_pkg::req_word_t        request,
  output logic                       response_valid,
  output lkvc_pkg::rsp_word_t        response,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CFG_BITS-1:0] cfg_data
);

  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int CMP_BITS  = (CNT_BITS > lkvc_pkg::CFG_BITS) ? CNT_BITS : lkvc_pkg::CFG_BITS;
  localparam int KV_BITS   = KEY_BITS + 32;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state;

  logic [lkvc_pkg::CFG_BITS-1:0] capacity;
  logic [CNT_BITS-1:0]           occupancy;
  logic [ENTRIES-1:0]            valid;

  lkvc_pkg::req_word_t cur;
  logic [KEY_BITS-1:0] key_m;
  logic [95:0]         key_wide;

  logic [CNT_BITS-1:0] cnt;
  logic                rd_pend;
  logic [IDX_BITS-1:0] rd_idx;

  logic                found;
  logic [IDX_BITS-1:0] found_idx;
  logic [IDX_BITS-1:0] found_rank;
  logic signed [31:0]  found_val;
  logic                free_found;
  logic [IDX_BITS-1:0] free_idx;
  logic [IDX_BITS-1:0] lru_idx;
  logic [IDX_BITS-1:0] lru2_idx;

  logic [IDX_BITS-1:0] target;
  logic [IDX_BITS-1:0] thr;
  logic                inc_all;

  logic                kv_we;
  logic [IDX_BITS-1:0] kv_waddr;
  logic [KV_BITS-1:0]  kv_wdata;
  logic [KV_BITS-1:0]  kv_rdata;
  logic                rank_we;
  logic [IDX_BITS-1:0] rank_wdata;
  logic [IDX_BITS-1:0] rank_rdata;
  logic [IDX_BITS-1:0] raddr;

  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_BITS-1:0] rank_ext;
  logic [CNT_BITS-1:0] occ_m1;
  logic [CNT_BITS-1:0] occ_m2;
  logic [CMP_BITS-1:0] cap_ext;
  logic [CMP_BITS-1:0] eff_cap;
  logic [CMP_BITS-1:0] occ_ext;
  logic                cap_full;
  logic                cap_over;
  logic                is_put;
  logic [IDX_BITS-1:0] evict_idx;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  // Keys are sign extended and then cut to the stored key width.
  assign key_wide = {{64{request.key[31]}}, request.key};

  assign raddr    = cnt[IDX_BITS-1:0];
  assign rd_key   = kv_rdata[KV_BITS-1:32];
  assign rank_ext = CNT_BITS'(rank_rdata);
  assign occ_m1   = occupancy - 1'b1;
  assign occ_m2   = occupancy - 2'd2;

  always_comb begin
    cap_ext = CMP_BITS'(capacity);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
      eff_cap = CMP_BITS'(ENTRIES);
    end
  end

  assign occ_ext   = CMP_BITS'(occupancy);
  assign cap_full  = (occ_ext >= eff_cap);
  assign cap_over  = (occ_ext > eff_cap);
  assign is_put    = (cur.command == lkvc_pkg::CMD_PUT);
  // If the hit entry was the least recent, the touch makes the next one least recent.
  assign evict_idx = (found_idx == lru_idx) ? lru2_idx : lru_idx;

  always_comb begin
    kv_we    = (state == ST_DECIDE) && is_put;
    kv_wdata = {key_m, cur.value};
    if (found) begin
      kv_waddr = found_idx;
    end else if (!cap_full) begin
      kv_waddr = free_idx;
    end else begin
      kv_waddr = lru_idx;
    end
  end

  always_comb begin
    rank_we    = 1'b0;
    rank_wdata = rank_rdata + 1'b1;
    if (rd_idx == target) begin
      rank_wdata = '0;
    end
    if ((state == ST_UPDATE) && rd_pend && valid[rd_idx]) begin
      rank_we = (rd_idx == target) || inc_all || (rank_rdata < thr);
    end
  end

  lkvc_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(KV_BITS)
  ) u_kv_ram (
    .clk  (clk),
    .we   (kv_we),
    .waddr(kv_waddr),
    .wdata(kv_wdata),
    .raddr(raddr),
    .rdata(kv_rdata)
  );

  lkvc_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(IDX_BITS)
  ) u_rank_ram (
    .clk  (clk),
    .we   (rank_we),
    .waddr(rd_idx),
    .wdata(rank_wdata),
    .raddr(raddr),
    .rdata(rank_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      occupancy      <= '0;
      valid          <= '0;
      response_valid <= 1'b0;
      rd_pend        <= 1'b0;
      cnt            <= '0;
    end else begin
      response_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cur        <= request;
            key_m      <= key_wide[KEY_BITS-1:0];
            cnt        <= '0;
            rd_pend    <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (cnt < CNT_BITS'(ENTRIES)) begin
            cnt     <= cnt + 1'b1;
            rd_pend <= 1'b1;
            rd_idx  <= raddr;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (valid[rd_idx]) begin
              if (!found && (rd_key == key_m)) begin
                found      <= 1'b1;
                found_idx  <= rd_idx;
                found_rank <= rank_rdata;
                found_val  <= kv_rdata[31:0];
              end
              if (rank_ext == occ_m1) begin
                lru_idx <= rd_idx;
              end
              if (rank_ext == occ_m2) begin
                lru2_idx <= rd_idx;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_idx == LAST_IDX) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          cnt     <= '0;
          rd_pend <= 1'b0;
          if (!is_put) begin
            response.evicted <= 1'b0;
            if (found) begin
              response.hit        <= 1'b1;
              response.read_value <= found_val;
              target              <= found_idx;
              thr                 <= found_rank;
              inc_all             <= 1'b0;
              state               <= ST_UPDATE;
            end else begin
              response.hit        <= 1'b0;
              response.read_value <= '0;
              response_valid      <= 1'b1;
              state               <= ST_IDLE;
            end
          end else begin
            response.read_value <= '0;
            response.hit        <= found;
            target              <= kv_waddr;
            state               <= ST_UPDATE;
            if (found) begin
              thr     <= found_rank;
              inc_all <= 1'b0;
              if (cap_over) begin
                valid[evict_idx] <= 1'b0;
                occupancy        <= occupancy - 1'b1;
                response.evicted <= 1'b1;
              end else begin
                response.evicted <= 1'b0;
              end
            end else if (!cap_full) begin
              valid[free_idx]  <= 1'b1;
              occupancy        <= occupancy + 1'b1;
              inc_all          <= 1'b1;
              response.evicted <= 1'b0;
            end else begin
              inc_all          <= 1'b1;
              response.evicted <= 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          if (cnt < CNT_BITS'(ENTRIES)) begin
            cnt     <= cnt + 1'b1;
            rd_pend <= 1'b1;
            rd_idx  <= raddr;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && (rd_idx == LAST_IDX)) begin
            response_valid <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
